[hdl/rcm_pkg.sv]
package rcm_pkg;

	localparam int ADC_BITS_DEF   = 10;
	localparam int MAX_WINDOW_DEF = 4096;

	localparam int ZO_W   = 10;
	localparam int WIN_W  = 13;
	localparam int SENS_W = 10;
	localparam int LV_W   = 9;
	localparam int CFG_W  = 13;
	localparam int IDX_W  = 2;

	localparam int SUM_W  = 33;
	localparam int RMS_W  = 18;
	localparam int CUR_W  = 23;
	localparam int PWR_W  = 21;

	localparam int ZO_RST   = 512;
	localparam int WIN_RST  = 1000;
	localparam int SENS_RST = 100;
	localparam int LV_RST   = 230;

	// mean is shifted left by 16 before the root
	localparam int FRAC_SHIFT = 16;
	localparam int ROOT_W     = (SUM_W + FRAC_SHIFT + 1) / 2;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int REM_W      = ROOT_W + 3;
	localparam int PROD_W     = ROOT_W + CUR_W;

	localparam int CUR_SCALE  = 5000000;
	localparam int SENS_SHIFT = 18;
	localparam int PWR_DIV    = 1000;
	localparam int CUR_MAX    = 5000000;
	localparam int PWR_MAX    = 2000000;

	// divide by 1000 as a reciprocal multiply and shift, exact for 32-bit products
	localparam int PWR_RECIP       = 274877907;
	localparam int PWR_RECIP_W     = 29;
	localparam int PWR_RECIP_SHIFT = 38;
	localparam int PDIV_W          = CUR_W + LV_W + PWR_RECIP_W;
	localparam int PWR_Q_W         = PDIV_W - PWR_RECIP_SHIFT;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_ZERO_OFFSET,
		REG_WINDOW_LENGTH,
		REG_SENSITIVITY,
		REG_LINE_VOLTAGE
	} cfg_reg_t;

	typedef struct packed {
		logic [ZO_W-1:0]   zero_offset;
		logic [WIN_W-1:0]  window_length;
		logic [SENS_W-1:0] sensitivity;
		logic [LV_W-1:0]   line_voltage;
	} cfg_t;

	// one closed window handed to the back end
	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic [WIN_W-1:0]  win;
		logic [SENS_W-1:0] sens;
		logic [LV_W-1:0]   lv;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MEAN,
		ST_ROOT,
		ST_MULC,
		ST_DIVC_GO,
		ST_DIVC,
		ST_MULP,
		ST_DIVP_GO,
		ST_DIVP,
		ST_DONE
	} back_state_t;

endpackage

[hdl/rcm_front.sv]
module rcm_front import rcm_pkg::*; #(
	parameter int ADC_BITS   = ADC_BITS_DEF,
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ADC_BITS-1:0] adc_sample,
	input  logic                q_full,
	output logic                q_push,
	output job_t                q_job
);

	localparam int DIFF_W = (ADC_BITS > ZO_W) ? ADC_BITS : ZO_W;
	localparam int SQ_W   = 2 * DIFF_W;

	logic [SUM_W-1:0]  sum_q;
	logic [WIN_W-1:0]  count_q;
	logic [WIN_W-1:0]  count_inc;
	logic [WIN_W-1:0]  win;
	logic [SENS_W-1:0] sens;
	logic [DIFF_W-1:0] samp_ext;
	logic [DIFF_W-1:0] zo_ext;
	logic [DIFF_W-1:0] diff;
	logic [SQ_W-1:0]   sq;
	logic [SUM_W-1:0]  sum_next;
	logic              close;
	logic              accept;

	always_comb begin
		if (cfg.window_length == '0) begin
			win = WIN_W'(1);
		end else if (32'(cfg.window_length) > MAX_WINDOW) begin
			win = WIN_W'(MAX_WINDOW);
		end else begin
			win = cfg.window_length;
		end
	end

	assign sens      = (cfg.sensitivity == '0) ? SENS_W'(1) : cfg.sensitivity;
	assign samp_ext  = DIFF_W'(adc_sample);
	assign zo_ext    = DIFF_W'(cfg.zero_offset);
	assign diff      = (samp_ext >= zo_ext) ? samp_ext - zo_ext : zo_ext - samp_ext;
	assign sq        = SQ_W'(diff) * SQ_W'(diff);
	assign sum_next  = sum_q + SUM_W'(sq);
	assign count_inc = count_q + WIN_W'(1);
	assign close     = (count_inc >= win);

	// stall only when this word would close a window and the queue is full
	assign in_ready = !(close && q_full);
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && close;

	always_comb begin
		q_job.sum  = sum_next;
		q_job.win  = win;
		q_job.sens = sens;
		q_job.lv   = cfg.line_voltage;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			sum_q   <= close ? '0 : sum_next;
			count_q <= close ? '0 : count_inc;
		end
	end

endmodule

[hdl/rcm_fifo.sv]
module rcm_fifo import rcm_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push)
		else $error("window queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("window queue read while empty");

endmodule

[hdl/rcm_divider.sv]
module rcm_divider import rcm_pkg::*; #(
	parameter int NUM_W = SUM_W,
	parameter int DEN_W = WIN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});
	assign done  = done_q;
	assign quot  = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q && !done_q)
		else $error("divider restarted before it finished");

endmodule

[hdl/rcm_back.sv]
module rcm_back import rcm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  job_t             q_head,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [RMS_W-1:0] rms_counts_q8,
	output logic [CUR_W-1:0] current_ma,
	output logic [PWR_W-1:0] power_va
);

	localparam int RCNT_W = $clog2(ROOT_W + 1);

	back_state_t        state_q;
	back_state_t        state_d;
	job_t               job_q;
	logic [RAD_W-1:0]   rad_q;
	logic [REM_W-1:0]   rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [RCNT_W-1:0]  root_cnt_q;
	logic [PROD_W-1:0]  prod_q;
	logic [PDIV_W-1:0]  pdiv_q;
	logic [CUR_W-1:0]   cur_q;
	logic [PWR_W-1:0]   pwr_q;
	logic               out_valid_q;
	logic [RMS_W-1:0]   rms_out_q;
	logic [CUR_W-1:0]   cur_out_q;
	logic [PWR_W-1:0]   pwr_out_q;

	logic               div_start;
	logic [SUM_W-1:0]   div_num;
	logic [WIN_W-1:0]   div_den;
	logic               div_done;
	logic [SUM_W-1:0]   div_quot;

	logic [REM_W-1:0]   rem_sh;
	logic [REM_W-1:0]   root_trial;
	logic               root_fits;
	logic               out_load;

	rcm_divider #(
		.NUM_W(SUM_W),
		.DEN_W(WIN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	// digit-by-digit square root, two radicand bits per cycle
	assign rem_sh     = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign root_trial = {1'b0, root_q, 2'b01};
	assign root_fits  = (rem_sh >= root_trial);

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		div_num   = q_head.sum;
		div_den   = q_head.win;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop     = 1'b1;
					div_start = 1'b1;
					state_d   = ST_MEAN;
				end
			end
			ST_MEAN: begin
				if (div_done) begin
					state_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (root_cnt_q == RCNT_W'(1)) begin
					state_d = ST_MULC;
				end
			end
			ST_MULC: begin
				state_d = ST_DIVC_GO;
			end
			ST_DIVC_GO: begin
				div_start = 1'b1;
				div_num   = SUM_W'(prod_q[PROD_W-1:SENS_SHIFT]);
				div_den   = WIN_W'(job_q.sens);
				state_d   = ST_DIVC;
			end
			ST_DIVC: begin
				if (div_done) begin
					state_d = ST_MULP;
				end
			end
			ST_MULP: begin
				state_d = ST_DIVP_GO;
			end
			ST_DIVP_GO: begin
				state_d = ST_DIVP;
			end
			ST_DIVP: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
		if (state_q == ST_MEAN && div_done) begin
			rad_q      <= RAD_W'({div_quot, FRAC_SHIFT'(0)});
			rem_q      <= '0;
			root_q     <= '0;
			root_cnt_q <= RCNT_W'(ROOT_W);
		end else if (state_q == ST_ROOT) begin
			rad_q      <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q      <= root_fits ? rem_sh - root_trial : rem_sh;
			root_q     <= {root_q[ROOT_W-2:0], root_fits};
			root_cnt_q <= root_cnt_q - RCNT_W'(1);
		end
		if (state_q == ST_MULC) begin
			prod_q <= PROD_W'(root_q) * PROD_W'(CUR_SCALE);
		end else if (state_q == ST_MULP) begin
			prod_q <= PROD_W'(cur_q) * PROD_W'(job_q.lv);
		end
		if (state_q == ST_DIVC && div_done) begin
			cur_q <= (div_quot > SUM_W'(CUR_MAX)) ? CUR_W'(CUR_MAX) : div_quot[CUR_W-1:0];
		end
		// power over 1000 by reciprocal multiply, then shift and clip
		if (state_q == ST_DIVP_GO) begin
			pdiv_q <= PDIV_W'(prod_q[CUR_W+LV_W-1:0]) * PDIV_W'(PWR_RECIP);
		end
		if (state_q == ST_DIVP) begin
			pwr_q <= (pdiv_q[PDIV_W-1:PWR_RECIP_SHIFT] > PWR_Q_W'(PWR_MAX)) ?
				PWR_W'(PWR_MAX) : pdiv_q[PWR_RECIP_SHIFT +: PWR_W];
		end
		if (out_load) begin
			rms_out_q <= root_q[RMS_W-1:0];
			cur_out_q <= cur_q;
			pwr_out_q <= pwr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign rms_counts_q8 = rms_out_q;
	assign current_ma    = cur_out_q;
	assign power_va      = pwr_out_q;

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result word raised outside the done state");

endmodule

[hdl/rms_current_meter.sv]
// Accumulation: one sample per cycle while in_ready holds; a sample is summed at the edge
// that accepts it. Result path: the 33-step divider (mean), the 25-step square root, the
// divider again (current), then a reciprocal multiply and clip for power. Throughput: one
// sample per cycle unless a closing sample meets a full queue; a two-entry window queue
// absorbs closes while the back end is busy, then input stalls.
// Reset: asynchronous, clears sum, count, queue and result valid; config returns to defaults.
module rms_current_meter import rcm_pkg::*; #(
	parameter int ADC_BITS   = ADC_BITS_DEF,
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ADC_BITS-1:0] adc_sample,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [RMS_W-1:0]    rms_counts_q8,
	output logic [CUR_W-1:0]    current_ma,
	output logic [PWR_W-1:0]    power_va
);

	cfg_t cfg_q;
	job_t push_job;
	job_t head_job;
	logic q_push;
	logic q_pop;
	logic q_empty;
	logic q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_offset   <= ZO_W'(ZO_RST);
			cfg_q.window_length <= WIN_W'(WIN_RST);
			cfg_q.sensitivity   <= SENS_W'(SENS_RST);
			cfg_q.line_voltage  <= LV_W'(LV_RST);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ZERO_OFFSET:   cfg_q.zero_offset   <= cfg_data[ZO_W-1:0];
				REG_WINDOW_LENGTH: cfg_q.window_length <= cfg_data[WIN_W-1:0];
				REG_SENSITIVITY:   cfg_q.sensitivity   <= cfg_data[SENS_W-1:0];
				REG_LINE_VOLTAGE:  cfg_q.line_voltage  <= cfg_data[LV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rcm_front #(
		.ADC_BITS  (ADC_BITS),
		.MAX_WINDOW(MAX_WINDOW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.adc_sample(adc_sample),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	rcm_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(push_job),
		.pop     (q_pop),
		.head    (head_job),
		.empty   (q_empty),
		.full    (q_full)
	);

	rcm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (head_job),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rms_counts_q8(rms_counts_q8),
		.current_ma   (current_ma),
		.power_va     (power_va)
	);

endmodule

[tb/sv/rms_current_meter_tb.sv]
`timescale 1ns / 1ps
module rms_current_meter_tb;
	import rcm_pkg::*;

	typedef struct {
		logic [RMS_W-1:0] rms;
		logic [CUR_W-1:0] cur;
		logic [PWR_W-1:0] pwr;
	} meter_result_t;

	class rms_scoreboard;
		logic [ZO_W-1:0]   zero_offset;
		logic [WIN_W-1:0]  window_length;
		logic [SENS_W-1:0] sensitivity;
		logic [LV_W-1:0]   line_voltage;
		logic [SUM_W-1:0]  square_sum;
		logic [WIN_W-1:0]  sample_count;
		meter_result_t     expected_q[$];
		int                mismatches;

		function new();
			zero_offset   = ZO_W'(ZO_RST);
			window_length = WIN_W'(WIN_RST);
			sensitivity   = SENS_W'(SENS_RST);
			line_voltage  = LV_W'(LV_RST);
			square_sum    = '0;
			sample_count  = '0;
			mismatches    = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] d);
			case (idx)
				REG_ZERO_OFFSET:   zero_offset   = d[ZO_W-1:0];
				REG_WINDOW_LENGTH: window_length = d[WIN_W-1:0];
				REG_SENSITIVITY:   sensitivity   = d[SENS_W-1:0];
				REG_LINE_VOLTAGE:  line_voltage  = d[LV_W-1:0];
				default: ;
			endcase
		endfunction

		// bit-serial root, one result bit per pass; radicand stays below 2^50
		function longint unsigned root_floor(longint unsigned v);
			longint unsigned r;
			longint unsigned t;
			r = 0;
			for (int b = 25; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= v)
					r = t;
			end
			return r;
		endfunction

		function void note_sample(logic [ADC_BITS_DEF-1:0] s);
			logic [ZO_W-1:0] diff;
			longint unsigned win;
			longint unsigned sens;
			longint unsigned mean;
			longint unsigned rms;
			longint unsigned cur;
			longint unsigned pwr;
			meter_result_t   r;
			diff = (s >= zero_offset) ? s - zero_offset : zero_offset - s;
			square_sum = square_sum + diff * diff;
			sample_count = sample_count + 1'b1;
			win = window_length;
			if (win == 0)
				win = 1;
			if (win > MAX_WINDOW_DEF)
				win = MAX_WINDOW_DEF;
			if (sample_count < win)
				return;
			mean = square_sum / win;
			rms = root_floor(mean << FRAC_SHIFT);
			sens = (sensitivity == 0) ? 1 : sensitivity;
			cur = (rms * CUR_SCALE) / ((64'd1 << SENS_SHIFT) * sens);
			if (cur > CUR_MAX)
				cur = CUR_MAX;
			pwr = (cur * line_voltage) / PWR_DIV;
			if (pwr > PWR_MAX)
				pwr = PWR_MAX;
			r.rms = rms[RMS_W-1:0];
			r.cur = cur[CUR_W-1:0];
			r.pwr = pwr[PWR_W-1:0];
			expected_q.push_back(r);
			square_sum = '0;
			sample_count = '0;
		endfunction

		function void report(string what, longint unsigned e, longint unsigned a);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, e, a);
		endfunction

		function void check_result(logic [RMS_W-1:0] rms, logic [CUR_W-1:0] cur,
				logic [PWR_W-1:0] pwr);
			meter_result_t e;
			if (expected_q.size() == 0) begin
				report("unexpected word, rms", 0, rms);
				return;
			end
			e = expected_q.pop_front();
			if (rms !== e.rms)
				report("rms_counts_q8", e.rms, rms);
			if (cur !== e.cur)
				report("current_ma", e.cur, cur);
			if (pwr !== e.pwr)
				report("power_va", e.pwr, pwr);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void flush_leftovers();
			while (expected_q.size() != 0)
				report("missing word, rms", expected_q.pop_front().rms, 0);
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_we;
	logic [IDX_W-1:0]        cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [ADC_BITS_DEF-1:0] adc_sample;
	logic                    out_valid;
	logic                    out_ready;
	logic [RMS_W-1:0]        rms_counts_q8;
	logic [CUR_W-1:0]        current_ma;
	logic [PWR_W-1:0]        power_va;

	int            src_idle_pct;
	int            sink_stall_pct;
	int            hold_left;
	rms_scoreboard meter_sb;

	rms_current_meter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.adc_sample(adc_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rms_counts_q8(rms_counts_q8),
		.current_ma(current_ma),
		.power_va(power_va)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver: a counted hold-off wins over the random stall
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && meter_sb != null) begin
			if (out_valid && out_ready)
				meter_sb.check_result(rms_counts_q8, current_ma, power_va);
			if (in_valid && in_ready)
				meter_sb.note_sample(adc_sample);
		end
	end

	task automatic push_sample(input logic [ADC_BITS_DEF-1:0] v);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		adc_sample <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		meter_sb.write_reg(idx, d);
	endtask

	// drop valid, wait out every pending word, then give the back end time to go idle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (meter_sb.pending() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [ADC_BITS_DEF-1:0] pick_sample();
		int pick;
		int v;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		if (pick < 6)
			return ADC_BITS_DEF'($urandom_range(0, 1023));
		// hover around the zero point
		v = int'(meter_sb.zero_offset) + $urandom_range(0, 16) - 8;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return v[ADC_BITS_DEF-1:0];
	endfunction

	task automatic pick_config();
		int pick;
		logic [CFG_W-1:0] w;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			w = 0;
		else if (pick < 3)
			w = CFG_W'($urandom_range(13, 300));
		else
			w = CFG_W'($urandom_range(1, 12));
		write_reg(REG_WINDOW_LENGTH, w);
		pick = $urandom_range(0, 5);
		write_reg(REG_ZERO_OFFSET, pick == 0 ? 13'd0 : pick == 1 ? 13'd1023 :
			CFG_W'($urandom_range(0, 8191)));
		pick = $urandom_range(0, 5);
		write_reg(REG_SENSITIVITY, pick == 0 ? 13'd0 : pick == 1 ? 13'd1023 :
			pick == 2 ? 13'd1 : CFG_W'($urandom_range(0, 8191)));
		pick = $urandom_range(0, 5);
		write_reg(REG_LINE_VOLTAGE, pick == 0 ? 13'd0 : pick == 1 ? 13'd511 :
			CFG_W'($urandom_range(0, 8191)));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ZERO_OFFSET;
		cfg_data = '0;
		in_valid = 1'b0;
		adc_sample = '0;
		out_ready = 1'b0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_left = 0;
		meter_sb = new();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// single-sample windows at the field extremes
		write_reg(REG_WINDOW_LENGTH, 1);
		push_sample(0);
		push_sample(1023);
		push_sample(512);
		push_sample(511);
		push_sample(513);
		drain();
		// zero window behaves as one
		write_reg(REG_WINDOW_LENGTH, 0);
		push_sample(1023);
		push_sample(0);
		drain();
		// zero sensitivity, top line voltage: power clips
		write_reg(REG_ZERO_OFFSET, 0);
		write_reg(REG_SENSITIVITY, 0);
		write_reg(REG_LINE_VOLTAGE, 511);
		push_sample(1023);
		push_sample(0);
		push_sample(1);
		drain();
		write_reg(REG_ZERO_OFFSET, 1023);
		write_reg(REG_SENSITIVITY, 1000);
		write_reg(REG_LINE_VOLTAGE, 400);
		push_sample(0);
		push_sample(1023);
		drain();
		write_reg(REG_LINE_VOLTAGE, 0);
		push_sample(0);
		drain();
		// shorten the window below the running count; next sample closes it
		write_reg(REG_ZERO_OFFSET, 512);
		write_reg(REG_LINE_VOLTAGE, 230);
		write_reg(REG_WINDOW_LENGTH, 20);
		for (int i = 0; i < 6; i++)
			push_sample(ADC_BITS_DEF'($urandom_range(0, 1023)));
		drain();
		write_reg(REG_WINDOW_LENGTH, 3);
		push_sample(ADC_BITS_DEF'($urandom_range(0, 1023)));
		drain();

		for (int p = 0; p < 12; p++) begin
			case (p % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
				default: begin src_idle_pct = 26; sink_stall_pct = 26; end
			endcase
			pick_config();
			for (int i = 0; i < 100; i++)
				push_sample(pick_sample());
			drain();
		end

		// long receiver hold-off with one-sample windows: queue fills, input stalls
		src_idle_pct = 0;
		sink_stall_pct = 0;
		write_reg(REG_WINDOW_LENGTH, 1);
		hold_left = 400;
		for (int i = 0; i < 40; i++)
			push_sample(pick_sample());
		drain();

		// oversized window clips at the maximum: no word while the count is short of it,
		// then a short window closes on the sum built so far
		write_reg(REG_WINDOW_LENGTH, 8191);
		write_reg(REG_ZERO_OFFSET, CFG_W'($urandom_range(0, 1023)));
		for (int i = 0; i < 100; i++)
			push_sample(pick_sample());
		drain();
		write_reg(REG_WINDOW_LENGTH, 2);
		push_sample(pick_sample());
		drain();

		meter_sb.flush_leftovers();
		if (meter_sb.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

endmodule

[files.f]
hdl/rcm_pkg.sv
hdl/rcm_front.sv
hdl/rcm_fifo.sv
hdl/rcm_divider.sv
hdl/rcm_back.sv
hdl/rms_current_meter.sv
tb/sv/rms_current_meter_tb.sv
